[hdl/fp32_vector_alu_with_reduction_defines.svh]
// Assertion macros for the fp32 vector ALU checker.
`ifndef FP32_VECTOR_ALU_WITH_REDUCTION_DEFINES_SVH
`define FP32_VECTOR_ALU_WITH_REDUCTION_DEFINES_SVH

// Checked outside reset only.
`define FVR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define FVR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/fvr_pkg.sv]
package fvr_pkg;

  localparam logic [2:0] KIND_ADD   = 3'd0;
  localparam logic [2:0] KIND_SUB   = 3'd1;
  localparam logic [2:0] KIND_MUL   = 3'd2;
  localparam logic [2:0] KIND_SCALE = 3'd3;
  localparam logic [2:0] KIND_RELU  = 3'd4;
  localparam logic [2:0] KIND_CLIP  = 3'd5;
  localparam logic [2:0] KIND_DOT   = 3'd6;
  localparam logic [2:0] KIND_SUM   = 3'd7;

  localparam logic REG_SCALE = 1'b0;
  localparam logic REG_CLIP  = 1'b1;

  localparam int PADDR_W = 3;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
  localparam logic [31:0] FP_ONE    = 32'h3F80_0000;
  localparam logic [31:0] FP_ZERO   = 32'h0000_0000;

  localparam int IN_DEPTH_DEF  = 4;
  localparam int OUT_DEPTH_DEF = 4;

  typedef struct packed {
    logic [2:0] kind;
    logic       red;
    logic       last;
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] a;
    logic [31:0] b;
  } entry_t;

  typedef struct packed {
    logic [31:0] value;
    logic        red;
  } res_t;

  typedef struct packed {
    logic               sign;
    logic               nan;
    logic               inf;
    logic               zero;
    logic signed [10:0] e;
    logic [47:0]        p;
  } mul_pre_t;

  function automatic logic is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
  endfunction

  function automatic logic [5:0] lzc48(input logic [47:0] m);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (m[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  // m normalized (bit 47 set), e biased exponent of that leading one
  function automatic logic [31:0] fp_round(input logic sign, input logic signed [10:0] e,
                                           input logic [47:0] m);
    logic [47:0] q;
    logic        stk;
    logic [7:0]  ef;
    logic [30:0] w;
    logic        inc;
    int          sh;
    q   = m;
    stk = 1'b0;
    ef  = e[7:0];
    sh  = 1 - int'(e);
    if (e >= 11'sd255) begin
      return {sign, 8'hFF, 23'd0};
    end
    if (e < 11'sd1) begin
      ef = 8'd0;
      if (sh >= 48) begin
        q   = 48'd0;
        stk = |m;
      end else begin
        q   = m >> sh;
        stk = |(m & ((48'd1 << sh) - 48'd1));
      end
    end
    w   = {ef, q[46:24]};
    inc = q[23] & (stk | (|q[22:0]) | q[24]);
    w   = w + {30'd0, inc};
    return {sign, w};
  endfunction

  function automatic mul_pre_t fp_mul_pre(input logic [31:0] x, input logic [31:0] y);
    mul_pre_t r;
    logic [7:0] ex, ey;
    ex     = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey     = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    r.sign = x[31] ^ y[31];
    r.p    = {x[30:23] != 8'd0, x[22:0]} * {y[30:23] != 8'd0, y[22:0]};
    r.zero = (x[30:0] == 31'd0) || (y[30:0] == 31'd0);
    r.inf  = is_inf(x) || is_inf(y);
    r.nan  = is_nan(x) || is_nan(y) || (r.inf && r.zero);
    r.e    = $signed({3'b000, ex}) + $signed({3'b000, ey}) - 11'sd126;
    return r;
  endfunction

  function automatic logic [31:0] fp_mul_post(input mul_pre_t m);
    logic [5:0] lz;
    lz = lzc48(m.p);
    if (m.nan) return CANON_NAN;
    if (m.inf) return {m.sign, 8'hFF, 23'd0};
    if (m.zero) return {m.sign, 31'd0};
    return fp_round(m.sign, m.e - $signed({5'b00000, lz}), m.p << lz);
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] x, input logic [31:0] y);
    logic [31:0] big, sml;
    logic [7:0]  eb, es, d;
    logic [47:0] xm, ym, yf, s;
    logic        stk;
    logic [5:0]  lz;
    logic signed [10:0] e;
    if (x[30:0] >= y[30:0]) begin
      big = x;
      sml = y;
    end else begin
      big = y;
      sml = x;
    end
    eb  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d   = eb - es;
    xm  = {1'b0, big[30:23] != 8'd0, big[22:0], 23'd0};
    yf  = {1'b0, sml[30:23] != 8'd0, sml[22:0], 23'd0};
    if (d >= 8'd48) begin
      ym  = 48'd0;
      stk = |yf;
    end else begin
      ym  = yf >> d;
      stk = |(yf & ((48'd1 << d) - 48'd1));
    end
    ym[0] = ym[0] | stk;
    s     = (big[31] == sml[31]) ? xm + ym : xm - ym;
    lz    = lzc48(s);
    e     = $signed({3'b000, eb}) + 11'sd1 - $signed({5'b00000, lz});
    if (is_nan(x) || is_nan(y) || (is_inf(x) && is_inf(y) && (x[31] ^ y[31])))
      return CANON_NAN;
    if (is_inf(x)) return x;
    if (is_inf(y)) return y;
    if (s == 48'd0) return {big[31] & sml[31], 31'd0};
    return fp_round(big[31], e, s << lz);
  endfunction

  function automatic logic fp_gt(input logic [31:0] x, input logic [31:0] y);
    logic [31:0] ox, oy;
    ox = x[31] ? ~x : (x | SIGN_BIT);
    oy = y[31] ? ~y : (y | SIGN_BIT);
    if (is_nan(x) || is_nan(y)) return 1'b0;
    if ((x[30:0] == 31'd0) && (y[30:0] == 31'd0)) return 1'b0;
    return ox > oy;
  endfunction

endpackage

[hdl/fp32_vector_alu_with_reduction.sv]
// Path: push enters the input queue, then pipe registers s1 and s2, then the output queue.
// Throughput: one transaction per cycle; dot and sum chain one add per cycle on the accumulator.
// Both rates hold unless a full output queue stalls the two-stage multiply/round pipe.
// Reset (rst, synchronous): queues empty, accumulator +0, scale and clip registers 1.0.
module fp32_vector_alu_with_reduction #(
  parameter int IN_DEPTH  = fvr_pkg::IN_DEPTH_DEF,
  parameter int OUT_DEPTH = fvr_pkg::OUT_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [2:0]                  kind,
  input  logic [31:0]                 a_value,
  input  logic [31:0]                 b_value,
  input  logic                        last,
  output logic                        empty,
  input  logic                        pop,
  output logic [31:0]                 result_value,
  output logic                        is_reduction,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fvr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import fvr_pkg::*;

  entry_t      q_entry;
  logic        q_valid, q_pop;
  logic [31:0] clip_threshold;

  fvr_front #(.DEPTH(IN_DEPTH)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .kind(kind), .a_value(a_value), .b_value(b_value), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .clip_threshold(clip_threshold),
    .q_entry(q_entry), .q_valid(q_valid), .q_pop(q_pop)
  );

  fvr_back #(.DEPTH(OUT_DEPTH)) u_back (
    .clk(clk), .rst(rst),
    .q_entry(q_entry), .q_valid(q_valid), .q_pop(q_pop),
    .clip_threshold(clip_threshold),
    .result_value(result_value), .is_reduction(is_reduction),
    .empty(empty), .pop(pop)
  );
endmodule

[hdl/fvr_fifo.sv]
module fvr_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic do_wr, do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (do_rd) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (do_wr && !do_rd) count <= count + CW'(1);
      else if (do_rd && !do_wr) count <= count - CW'(1);
    end
  end
endmodule

[hdl/fvr_front.sv]
module fvr_front #(
  parameter int DEPTH = fvr_pkg::IN_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [2:0]                  kind,
  input  logic [31:0]                 a_value,
  input  logic [31:0]                 b_value,
  input  logic                        last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fvr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [31:0]                 clip_threshold,
  output fvr_pkg::entry_t             q_entry,
  output logic                        q_valid,
  input  logic                        q_pop
);
  import fvr_pkg::*;

  logic [31:0] scale_factor;
  logic        wr;
  entry_t      ent;
  logic        q_empty;
  logic [$bits(entry_t)-1:0] q_raw;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_CLIP) ? clip_threshold : scale_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor   <= FP_ONE;
      clip_threshold <= FP_ONE;
    end else if (wr) begin
      if (paddr[2] == REG_SCALE) scale_factor <= pwdata;
      else clip_threshold <= pwdata;
    end
  end

  always_comb begin
    ent.op.kind = kind;
    ent.op.red  = (kind == KIND_DOT) || (kind == KIND_SUM);
    ent.op.last = last;
    ent.a       = a_value;
    ent.b       = (kind == KIND_SCALE) ? scale_factor : b_value;
  end

  fvr_fifo #(.WIDTH($bits(entry_t)), .DEPTH(DEPTH)) u_inq (
    .clk(clk), .rst(rst),
    .wr_en(push), .wr_data(ent), .full(full),
    .rd_en(q_pop), .rd_data(q_raw), .empty(q_empty)
  );

  assign q_entry = entry_t'(q_raw);
  assign q_valid = !q_empty;
endmodule

[hdl/fvr_back.sv]
module fvr_back #(
  parameter int DEPTH = fvr_pkg::OUT_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  fvr_pkg::entry_t q_entry,
  input  logic            q_valid,
  output logic            q_pop,
  input  logic [31:0]     clip_threshold,
  output logic [31:0]     result_value,
  output logic            is_reduction,
  output logic            empty,
  input  logic            pop
);
  import fvr_pkg::*;

  logic        s1_valid, s2_valid;
  op_t         s1_op, s2_op;
  logic [31:0] s1_a, s1_b, s2_a, s2_b, s2_term;
  mul_pre_t    s1_mp;
  logic [31:0] accumulator;
  logic        en, emits, out_full;
  logic [31:0] add_x, add_y, add_r, res, neg_t;
  res_t        res_in;
  logic [$bits(res_t)-1:0] res_raw;

  assign emits = !s2_op.red || s2_op.last;
  assign en    = !(s2_valid && emits && out_full);
  assign q_pop = en && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= q_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op   <= q_entry.op;
      s1_a    <= q_entry.a;
      s1_b    <= q_entry.b;
      s1_mp   <= fp_mul_pre(q_entry.a, q_entry.b);
      s2_op   <= s1_op;
      s2_a    <= s1_a;
      s2_b    <= s1_b;
      s2_term <= (s1_op.kind == KIND_SUM) ? s1_a : fp_mul_post(s1_mp);
    end
  end

  assign neg_t = clip_threshold ^ SIGN_BIT;
  assign add_x = s2_op.red ? accumulator : s2_a;
  assign add_y = s2_op.red ? s2_term :
                 ((s2_op.kind == KIND_SUB) ? (s2_b ^ SIGN_BIT) : s2_b);
  assign add_r = fp_add(add_x, add_y);

  always_comb begin
    case (s2_op.kind)
      KIND_MUL, KIND_SCALE: res = s2_term;
      KIND_RELU: res = (!s2_a[31] && (s2_a[30:0] != 31'd0) && !is_nan(s2_a)) ? s2_a : FP_ZERO;
      KIND_CLIP: begin
        if (fp_gt(s2_a, clip_threshold)) res = clip_threshold;
        else if (fp_gt(neg_t, s2_a)) res = neg_t;
        else res = s2_a;
      end
      default: res = add_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= FP_ZERO;
    end else if (en && s2_valid && s2_op.red) begin
      accumulator <= s2_op.last ? FP_ZERO : add_r;
    end
  end

  assign res_in.value = res;
  assign res_in.red   = s2_op.red;

  fvr_fifo #(.WIDTH($bits(res_t)), .DEPTH(DEPTH)) u_outq (
    .clk(clk), .rst(rst),
    .wr_en(en && s2_valid && emits), .wr_data(res_in), .full(out_full),
    .rd_en(pop), .rd_data(res_raw), .empty(empty)
  );

  assign result_value = res_raw[32:1];
  assign is_reduction = res_raw[0];
endmodule

[hdl/fvr_checker.sv]
`include "fp32_vector_alu_with_reduction_defines.svh"

module fvr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        full,
  input logic                        empty,
  input logic                        pop,
  input logic [31:0]                 result_value,
  input logic                        is_reduction,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [fvr_pkg::PADDR_W-1:0] paddr,
  input logic [31:0]                 pwdata,
  input logic [31:0]                 prdata,
  input logic                        pready
);
  import fvr_pkg::*;

  `FVR_ASSERT_ALWAYS(a_reset_clears, rst |=> (empty && !full), "queues not clear after reset")
  `FVR_ASSERT(a_pready_high, pready, "pready low")
  `FVR_ASSERT(a_out_hold, (!empty && !pop) |=> (!empty && $stable(result_value) && $stable(is_reduction)), "waiting result changed")
  `FVR_ASSERT(a_scale_readback, (psel && penable && pwrite && paddr[2] == REG_SCALE) |=> (paddr[2] != REG_SCALE || prdata == $past(pwdata)), "scale register readback mismatch")
endmodule

bind fp32_vector_alu_with_reduction fvr_checker u_fvr_checker (.*);
